[sv/fbb_pkg.sv]
package fbb_pkg;

	localparam int ROW_BYTES    = 64;
	localparam int ROW_SHIFT    = $clog2(ROW_BYTES);
	localparam int ROW_COUNT    = 96;
	localparam int BUFFER_BYTES = ROW_BYTES * ROW_COUNT;
	localparam int STORE_DEPTH  = 2 * BUFFER_BYTES;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int OFF_W        = 15;
	localparam int BLIT_W       = 13;

	typedef enum logic [2:0] {
		ACT_PLOT       = 3'd0,
		ACT_PAIR       = 3'd1,
		ACT_FILL       = 3'd2,
		ACT_BLIT_START = 3'd3,
		ACT_BLIT_DATA  = 3'd4,
		ACT_SCROLL     = 3'd5,
		ACT_SWAP       = 3'd6,
		ACT_READ       = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	typedef struct packed {
		action_t    action;
		logic [6:0] pixel_x;
		logic [5:0] pair_column;
		logic [6:0] row;
		logic [6:0] width_pairs;
		logic [6:0] height_rows;
		logic [7:0] data_value;
		logic       buffer_select;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       drawing;
		logic       oor;
	} result_t;

endpackage

[sv/fbb_ram.sv]
module fbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/fbb_engine.sv]
module fbb_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fbb_pkg::item_t            item,
	input  logic                      start,
	output logic                      ready,
	output logic                      done,
	input  logic                      ack,
	output fbb_pkg::result_t          res,
	output logic                      mem_we,
	output logic [fbb_pkg::ADDR_W-1:0] mem_waddr,
	output logic [7:0]                mem_wdata,
	output logic                      mem_re,
	output logic [fbb_pkg::ADDR_W-1:0] mem_raddr,
	input  logic [7:0]                mem_rdata
);

	localparam int OW = fbb_pkg::OFF_W;
	localparam int AW = fbb_pkg::ADDR_W;
	localparam int BW = fbb_pkg::BLIT_W;
	localparam logic [OW-1:0] BUF_END   = OW'(fbb_pkg::BUFFER_BYTES);
	localparam logic [OW-1:0] ROW_STEP  = OW'(fbb_pkg::ROW_BYTES);
	localparam logic [AW-1:0] BUF_BASE  = AW'(fbb_pkg::BUFFER_BYTES);
	localparam logic [BW-1:0] BLIT_END  = BW'(fbb_pkg::BUFFER_BYTES);
	localparam logic [BW-1:0] BLIT_STEP = BW'(fbb_pkg::ROW_BYTES);

	fbb_pkg::state_t  state_q;
	fbb_pkg::action_t op_q;
	logic [OW-1:0]    row_base_q;
	logic [6:0]       col_q;
	logic [6:0]       row_q;
	logic [6:0]       w_q;
	logic [6:0]       h_q;
	logic [7:0]       val_q;
	logic             buf_q;
	logic             drawing_q;
	logic [7:0]       rdata_q;
	logic             oor_q;

	logic [BW-1:0]    blit_addr_q;
	logic [6:0]       blit_col_q;
	logic [6:0]       blit_width_q;
	logic [6:0]       blit_rows_q;

	logic             vld_s1;
	logic             rd_s1;
	logic             we_s1;
	logic             oor_s1;
	logic [AW-1:0]    waddr_s1;
	logic             fwd_s1;
	logic [7:0]       fwd_data_s1;

	// item decode
	logic [OW-1:0]    base;
	logic [OW-1:0]    plot_off;
	logic [OW-1:0]    blit_off;
	logic             blit_active;
	logic             sel_buf;
	logic [OW-1:0]    ld_start;
	logic [6:0]       ld_w;
	logic [6:0]       ld_h;
	logic             ld_empty;
	logic [7:0]       ld_val;
	logic             ld_buf;

	always_comb begin
		base        = OW'(item.pair_column) + (OW'(item.row) << fbb_pkg::ROW_SHIFT);
		plot_off    = OW'(item.pixel_x[6:1]) + (OW'(item.row) << fbb_pkg::ROW_SHIFT);
		blit_off    = OW'(blit_addr_q) + OW'(blit_col_q);
		blit_active = (blit_rows_q != 7'd0) && (blit_width_q != 7'd0);
		sel_buf     = item.buffer_select ? ~drawing_q : drawing_q;
		ld_start    = base;
		ld_w        = 7'd1;
		ld_h        = 7'd1;
		ld_empty    = 1'b0;
		ld_val      = item.data_value;
		ld_buf      = drawing_q;
		unique case (item.action) inside
			fbb_pkg::ACT_PLOT: begin
				ld_start = plot_off;
				ld_val   = item.pixel_x[0] ? {4'h0, item.data_value[3:0]}
				                           : {item.data_value[3:0], 4'h0};
			end
			fbb_pkg::ACT_PAIR: begin
			end
			fbb_pkg::ACT_FILL: begin
				ld_w     = item.width_pairs;
				ld_h     = item.height_rows;
				ld_empty = (item.width_pairs == 7'd0) || (item.height_rows == 7'd0);
			end
			fbb_pkg::ACT_BLIT_START, fbb_pkg::ACT_SWAP: begin
				ld_empty = 1'b1;
			end
			fbb_pkg::ACT_BLIT_DATA: begin
				ld_start = blit_off;
				ld_empty = !blit_active;
			end
			fbb_pkg::ACT_SCROLL: begin
				ld_w     = item.width_pairs;
				ld_h     = item.height_rows;
				ld_empty = (item.width_pairs == 7'd0) || (item.height_rows == 7'd0);
				ld_buf   = sel_buf;
			end
			fbb_pkg::ACT_READ: begin
				ld_buf = sel_buf;
			end
		endcase
	end

	// element issue
	logic [OW-1:0] off;
	logic [OW-1:0] src;
	logic          last_row;
	logic          last_col;
	logic          needs_read;
	logic          writes;
	logic          src_ok;
	logic          dst_ok;
	logic          issue;
	logic [7:0]    old;
	logic [7:0]    rd_val;

	always_comb begin
		off        = row_base_q + OW'(col_q);
		last_row   = (row_q + 7'd1) == h_q;
		last_col   = (col_q + 7'd1) == w_q;
		src        = (op_q == fbb_pkg::ACT_SCROLL) ? off + ROW_STEP : off;
		needs_read = (op_q == fbb_pkg::ACT_PLOT) || (op_q == fbb_pkg::ACT_READ) ||
		             ((op_q == fbb_pkg::ACT_SCROLL) && !last_row);
		writes     = op_q != fbb_pkg::ACT_READ;
		src_ok     = src < BUF_END;
		dst_ok     = off < BUF_END;
		issue      = state_q == fbb_pkg::ST_WALK;
		mem_re     = issue && needs_read && src_ok;
		mem_raddr  = AW'(src) + (buf_q ? BUF_BASE : '0);
	end

	always_comb begin
		old = 8'h00;
		if (rd_s1) begin
			old = fwd_s1 ? fwd_data_s1 : mem_rdata;
		end
		case (op_q)
			fbb_pkg::ACT_PLOT:   mem_wdata = old | val_q;
			fbb_pkg::ACT_SCROLL: mem_wdata = old;
			default:             mem_wdata = val_q;
		endcase
		rd_val    = (op_q == fbb_pkg::ACT_READ) ? old : 8'h00;
		mem_we    = vld_s1 && we_s1;
		mem_waddr = waddr_s1;
	end

	assign ready         = (state_q == fbb_pkg::ST_IDLE) ||
	                       ((state_q == fbb_pkg::ST_DONE) && ack);
	assign done          = state_q == fbb_pkg::ST_DONE;
	assign res.read_data = vld_s1 ? rd_val : rdata_q;
	assign res.drawing   = drawing_q;
	assign res.oor       = oor_q || (vld_s1 && oor_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbb_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				fbb_pkg::ST_IDLE: begin
					if (start) begin
						state_q <= ld_empty ? fbb_pkg::ST_DONE : fbb_pkg::ST_WALK;
					end
				end
				fbb_pkg::ST_WALK: begin
					if (last_row && last_col) begin
						state_q <= fbb_pkg::ST_DONE;
					end
				end
				fbb_pkg::ST_DONE: begin
					if (start) begin
						state_q <= ld_empty ? fbb_pkg::ST_DONE : fbb_pkg::ST_WALK;
					end else if (ack) begin
						state_q <= fbb_pkg::ST_IDLE;
					end
				end
			endcase
		end
	end

	// item context and walk counters
	always_ff @(posedge clk) begin
		if (start) begin
			op_q       <= item.action;
			row_base_q <= ld_start;
			col_q      <= 7'd0;
			row_q      <= 7'd0;
			w_q        <= ld_w;
			h_q        <= ld_h;
			val_q      <= ld_val;
			buf_q      <= ld_buf;
		end else if (issue) begin
			if (last_col) begin
				col_q      <= 7'd0;
				row_q      <= row_q + 7'd1;
				row_base_q <= row_base_q + ROW_STEP;
			end else begin
				col_q <= col_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drawing_q    <= 1'b1;
			blit_addr_q  <= '0;
			blit_col_q   <= 7'd0;
			blit_width_q <= 7'd0;
			blit_rows_q  <= 7'd0;
			rdata_q      <= 8'h00;
			oor_q        <= 1'b0;
			vld_s1       <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (start) begin
				rdata_q <= 8'h00;
				oor_q   <= 1'b0;
				if (item.action == fbb_pkg::ACT_SWAP) begin
					drawing_q <= ~drawing_q;
				end
				if (item.action == fbb_pkg::ACT_BLIT_START) begin
					blit_addr_q  <= (base < BUF_END) ? BW'(base) : BLIT_END;
					blit_col_q   <= 7'd0;
					blit_width_q <= item.width_pairs;
					blit_rows_q  <= item.height_rows;
				end
				if ((item.action == fbb_pkg::ACT_BLIT_DATA) && blit_active) begin
					if ({1'b0, blit_col_q} + 8'd1 >= {1'b0, blit_width_q}) begin
						blit_col_q  <= 7'd0;
						blit_rows_q <= blit_rows_q - 7'd1;
						blit_addr_q <= (blit_addr_q + BLIT_STEP > BLIT_END) ? BLIT_END :
						               blit_addr_q + BLIT_STEP;
					end else begin
						blit_col_q <= blit_col_q + 7'd1;
					end
				end
			end else if (vld_s1) begin
				rdata_q <= rd_val;
				oor_q   <= oor_q || oor_s1;
			end
		end
	end

	// second stage: read data arrives, write back
	always_ff @(posedge clk) begin
		rd_s1       <= needs_read && src_ok;
		we_s1       <= writes && dst_ok;
		oor_s1      <= writes && !dst_ok;
		waddr_s1    <= AW'(off) + (buf_q ? BUF_BASE : '0);
		fwd_s1      <= mem_we && (mem_waddr == mem_raddr);
		fwd_data_s1 <= mem_wdata;
	end

endmodule

[sv/nibble_framebuffer_blitter.sv]
// Two 128x96 frame buffers at four bits per pixel, one drawn into and one shown.
// Item channel: item_valid/item_ready carry one action beat (plot, write pair,
// fill, blit start, blit data, scroll up, swap, read) with its fields.
// Result channel: result_valid/result_ready return exactly one beat per item,
// in order: read_data (zero unless a read), drawing_buffer, shown_buffer and
// out_of_range, which is set when a write of that item fell past the buffer end.
// Single-byte actions walk one byte; a plot is a read-modify-write of its
// byte through the registered read port of the frame memory. Fill and scroll
// walk width*height bytes at one byte per cycle. Swap, blit start and empty
// rectangles walk no bytes. A new item is taken only after the previous item
// has finished its walk. A result register sits at the output: the next item
// is taken while a result waits, and a stalled receiver holds the result and
// stops the block at the end of the following item. Reset makes buffer 1 the
// drawing buffer and clears the blit cursor; frame memory contents are not
// cleared.
module nibble_framebuffer_blitter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [2:0] action,
	input  logic [6:0] pixel_x,
	input  logic [5:0] pair_column,
	input  logic [6:0] row,
	input  logic [6:0] width_pairs,
	input  logic [6:0] height_rows,
	input  logic [7:0] data_value,
	input  logic       buffer_select,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] read_data,
	output logic       drawing_buffer,
	output logic       shown_buffer,
	output logic       out_of_range
);

	fbb_pkg::item_t   item;
	fbb_pkg::result_t res;
	fbb_pkg::result_t res_q;
	logic             result_valid_q;
	logic             eng_ready;
	logic             eng_done;
	logic             ack;
	logic             start;

	logic                       mem_we;
	logic [fbb_pkg::ADDR_W-1:0] mem_waddr;
	logic [7:0]                 mem_wdata;
	logic                       mem_re;
	logic [fbb_pkg::ADDR_W-1:0] mem_raddr;
	logic [7:0]                 mem_rdata;

	always_comb begin
		item.action        = fbb_pkg::action_t'(action);
		item.pixel_x       = pixel_x;
		item.pair_column   = pair_column;
		item.row           = row;
		item.width_pairs   = width_pairs;
		item.height_rows   = height_rows;
		item.data_value    = data_value;
		item.buffer_select = buffer_select;
	end

	assign ack        = !result_valid_q || result_ready;
	assign item_ready = eng_ready;
	assign start      = item_valid && eng_ready;

	fbb_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.start     (start),
		.ready     (eng_ready),
		.done      (eng_done),
		.ack       (ack),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	fbb_ram #(
		.WIDTH (8),
		.DEPTH (fbb_pkg::STORE_DEPTH)
	) u_frame_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (eng_done && ack) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_done && ack) begin
			res_q <= res;
		end
	end

	assign result_valid   = result_valid_q;
	assign read_data      = res_q.read_data;
	assign drawing_buffer = res_q.drawing;
	assign shown_buffer   = ~res_q.drawing;
	assign out_of_range   = res_q.oor;

endmodule

[sv/fbb_checker.sv]
module fbb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] read_data,
	input logic       drawing_buffer,
	input logic       shown_buffer,
	input logic       out_of_range
);

	logic [2:0] pending_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = item_valid && item_ready;
	assign out_beat = result_valid && result_ready;

	// items taken but not yet returned
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else if (in_beat && !out_beat) begin
			pending_q <= pending_q + 3'd1;
		end else if (out_beat && !in_beat) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != 3'd0)
		else $error("result beat without an outstanding item");

	a_bounded_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd2)
		else $error("more than two items in flight");

	a_buffers_differ: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> shown_buffer != drawing_buffer)
		else $error("shown and drawing buffer are the same");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(read_data) &&
		$stable(drawing_buffer) && $stable(out_of_range))
		else $error("stalled result beat changed");

endmodule

bind nibble_framebuffer_blitter fbb_checker u_fbb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item_valid),
	.item_ready    (item_ready),
	.result_valid  (result_valid),
	.result_ready  (result_ready),
	.read_data     (read_data),
	.drawing_buffer(drawing_buffer),
	.shown_buffer  (shown_buffer),
	.out_of_range  (out_of_range)
);
